@@ rtl/core/mvwt_pkg.sv @@
`timescale 1ns / 1ps

package mvwt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int OUT_IDX_W   = 10;

    // Coordinate and distance widths
    localparam int COORD_BITS = 24;
    localparam int ABS_W      = COORD_BITS;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int SUM_W      = SQ_W + 2;

    // Weld tolerance: 10000 * dist^2 < min edge^2
    localparam int WELD_SCALE = 10000;
    localparam int SCALE_W    = 14;
    localparam int PROD_W     = SUM_W + SCALE_W;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
    } vec_t;

    // |a - b| of two signed coordinates
    function automatic logic [ABS_W-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] n;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        n = ~d + 1'b1;
        return d[COORD_BITS] ? n[ABS_W-1:0] : d[ABS_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] min_sum(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b
    );
        return (b < a) ? b : a;
    endfunction

endpackage

@@ rtl/core/mesh_vertex_weld_table.sv @@
`timescale 1ns / 1ps
// Operation: the edge lengths AB, BC and CA are measured first, then vertices a, b and c
//   are searched in turn against the stored vertices. A hit ends that vertex's search
//   early. A clear transfer resets the stored vertex count instead of searching.
// Throughput: one triangle at a time; the single RAM read port scans one stored
//   vertex per cycle. A finished result may wait in the output register meanwhile.
// Reset: control and vertex count clear at once; the vertex RAM is not cleared.
module mesh_vertex_weld_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               tri_valid,
    output logic                               tri_stall,
    input  logic                               op,
    input  logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_a_x,
    input  logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_a_y,
    input  logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_a_z,
    input  logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_b_x,
    input  logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_b_y,
    input  logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_b_z,
    input  logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_c_x,
    input  logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_c_y,
    input  logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_c_z,
    output logic                               weld_valid,
    input  logic                               weld_stall,
    output logic [mvwt_pkg::OUT_IDX_W-1:0]     index_a,
    output logic [mvwt_pkg::OUT_IDX_W-1:0]     index_b,
    output logic [mvwt_pkg::OUT_IDX_W-1:0]     index_c,
    output logic                               new_a,
    output logic                               new_b,
    output logic                               new_c,
    output logic                               table_full
);

    import mvwt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EDGE = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [1:0] EDGE_AB   = 2'd0;
    localparam logic [1:0] EDGE_BC   = 2'd1;
    localparam logic [1:0] EDGE_CA   = 2'd2;
    localparam logic [1:0] EDGE_NONE = 2'd3;

    localparam logic [1:0] VX_A = 2'd0;
    localparam logic [1:0] VX_B = 2'd1;
    localparam logic [1:0] VX_C = 2'd2;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [1:0]       vsel_reg, vsel_next;
    logic [1:0]       edge_cnt_reg, edge_cnt_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             weld_valid_reg, weld_valid_next;

    // Pipeline valids and tags
    logic             a_v_reg, a_v_next;
    logic             b_v_reg, b_v_next;
    logic             c_v_reg, c_v_next;
    logic             d_v_reg, d_v_next;
    logic             e_v_reg, e_v_next;
    logic             a_edge_reg, b_edge_reg, c_edge_reg, d_edge_reg;
    logic [IDX_W-1:0] a_tag_reg, b_tag_reg, c_tag_reg, d_tag_reg, e_tag_reg;

    // Pipeline payload
    logic [ABS_W-1:0]  b_dx_reg, b_dy_reg, b_dz_reg;
    logic [SQ_W-1:0]   c_sx_reg, c_sy_reg, c_sz_reg;
    logic [SUM_W-1:0]  d_sum_reg;
    logic [PROD_W-1:0] e_prod_reg;

    // Triangle and per-item working registers
    vec_t             va_reg, vb_reg, vc_reg;
    logic [SUM_W-1:0] ab_reg, bc_reg, ca_reg;
    logic [SUM_W-1:0] tol_reg;
    logic [IDX_W-1:0] res_idx_reg [3];
    logic [2:0]       res_new_reg;
    logic             res_full_reg;

    // Output register payload
    logic [OUT_IDX_W-1:0] index_a_reg, index_b_reg, index_c_reg;
    logic                 new_a_reg, new_b_reg, new_c_reg, table_full_reg;

    // Combinational helpers
    logic                  tri_xfer;
    logic                  issue_edge, issue_entry;
    logic                  scan_hit, scan_miss, pipe_busy, vtx_done, out_load;
    logic                  ram_we;
    logic [3*COORD_BITS-1:0] ram_rdata;
    vec_t                  cur_vec, ram_vec, p_vec, q_vec;
    logic [SQ_W-1:0]       sq_x, sq_y, sq_z;
    logic [SUM_W-1:0]      sum3, tol_pick;
    logic [PROD_W-1:0]     prod;

    assign tri_stall  = (state_reg != ST_IDLE);
    assign tri_xfer   = tri_valid && !tri_stall;
    assign weld_valid = weld_valid_reg;
    assign index_a    = index_a_reg;
    assign index_b    = index_b_reg;
    assign index_c    = index_c_reg;
    assign new_a      = new_a_reg;
    assign new_b      = new_b_reg;
    assign new_c      = new_c_reg;
    assign table_full = table_full_reg;

    // Vertex under search
    always_comb
    begin
        case (vsel_reg)
            VX_A:    cur_vec = va_reg;
            VX_B:    cur_vec = vb_reg;
            default: cur_vec = vc_reg;
        endcase
    end

    assign ram_vec = vec_t'(ram_rdata);

    // Scan control
    assign pipe_busy   = a_v_reg || b_v_reg || c_v_reg || d_v_reg || e_v_reg;
    assign scan_hit    = (state_reg == ST_SCAN) && e_v_reg && (e_prod_reg < PROD_W'(tol_reg));
    assign scan_miss   = (state_reg == ST_SCAN) && !scan_hit && (scan_reg == count_reg)
                         && !pipe_busy;
    assign vtx_done    = scan_hit || scan_miss;
    assign issue_edge  = (state_reg == ST_EDGE) && (edge_cnt_reg != EDGE_NONE);
    assign issue_entry = (state_reg == ST_SCAN) && !scan_hit && (scan_reg < count_reg);
    assign ram_we      = scan_miss && (count_reg != FULL_COUNT);
    assign out_load    = (state_reg == ST_DONE) && (!weld_valid_reg || !weld_stall);

    mvwt_ram #(
        .WIDTH (3 * COORD_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (cur_vec),
        .re    (issue_entry),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Stage A operand select: edge pairs or (vertex, stored entry)
    always_comb
    begin
        p_vec = cur_vec;
        q_vec = ram_vec;
        if (a_edge_reg)
        begin
            case (a_tag_reg[1:0])
                EDGE_AB:
                begin
                    p_vec = va_reg;
                    q_vec = vb_reg;
                end
                EDGE_BC:
                begin
                    p_vec = vb_reg;
                    q_vec = vc_reg;
                end
                default:
                begin
                    p_vec = vc_reg;
                    q_vec = va_reg;
                end
            endcase
        end
    end

    // Stage B squares, stage C sum, stage D scale
    assign sq_x = SQ_W'(b_dx_reg) * SQ_W'(b_dx_reg);
    assign sq_y = SQ_W'(b_dy_reg) * SQ_W'(b_dy_reg);
    assign sq_z = SQ_W'(b_dz_reg) * SQ_W'(b_dz_reg);
    assign sum3 = SUM_W'(c_sx_reg) + SUM_W'(c_sy_reg) + SUM_W'(c_sz_reg);
    assign prod = PROD_W'(d_sum_reg) * PROD_W'(WELD_SCALE);

    // Tolerance of the next vertex from its two adjacent edges
    always_comb
    begin
        case (vsel_reg)
            VX_A:    tol_pick = min_sum(ca_reg, ab_reg);
            VX_B:    tol_pick = min_sum(ab_reg, bc_reg);
            default: tol_pick = min_sum(ca_reg, bc_reg);
        endcase
    end

    // Control next state
    always_comb
    begin
        state_next      = state_reg;
        vsel_next       = vsel_reg;
        edge_cnt_next   = edge_cnt_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        weld_valid_next = weld_valid_reg && weld_stall;

        a_v_next = issue_edge || issue_entry;
        b_v_next = a_v_reg && !scan_hit;
        c_v_next = b_v_reg && !scan_hit;
        d_v_next = c_v_reg && !scan_hit;
        e_v_next = d_v_reg && !d_edge_reg && !scan_hit;

        if (out_load)
        begin
            weld_valid_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tri_xfer)
                begin
                    vsel_next     = VX_A;
                    edge_cnt_next = EDGE_AB;
                    if (op)
                    begin
                        count_next = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_EDGE;
                    end
                end
            end
            ST_EDGE:
            begin
                if (issue_edge)
                begin
                    edge_cnt_next = edge_cnt_reg + 2'd1;
                end
                if (d_v_reg && d_edge_reg && (d_tag_reg[1:0] == EDGE_CA))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                scan_next  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (issue_entry)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                if (ram_we)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (vtx_done)
                begin
                    if (vsel_reg == VX_C)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        vsel_next  = vsel_reg + 2'd1;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            vsel_reg       <= VX_A;
            edge_cnt_reg   <= EDGE_AB;
            count_reg      <= '0;
            scan_reg       <= '0;
            weld_valid_reg <= 1'b0;
            a_v_reg        <= 1'b0;
            b_v_reg        <= 1'b0;
            c_v_reg        <= 1'b0;
            d_v_reg        <= 1'b0;
            e_v_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            vsel_reg       <= vsel_next;
            edge_cnt_reg   <= edge_cnt_next;
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            weld_valid_reg <= weld_valid_next;
            a_v_reg        <= a_v_next;
            b_v_reg        <= b_v_next;
            c_v_reg        <= c_v_next;
            d_v_reg        <= d_v_next;
            e_v_reg        <= e_v_next;
        end
    end

    // Distance pipeline payload
    always_ff @(posedge clk)
    begin
        a_edge_reg <= issue_edge;
        a_tag_reg  <= issue_edge ? IDX_W'(edge_cnt_reg) : scan_reg[IDX_W-1:0];

        b_edge_reg <= a_edge_reg;
        b_tag_reg  <= a_tag_reg;
        b_dx_reg   <= abs_diff(p_vec.x, q_vec.x);
        b_dy_reg   <= abs_diff(p_vec.y, q_vec.y);
        b_dz_reg   <= abs_diff(p_vec.z, q_vec.z);

        c_edge_reg <= b_edge_reg;
        c_tag_reg  <= b_tag_reg;
        c_sx_reg   <= sq_x;
        c_sy_reg   <= sq_y;
        c_sz_reg   <= sq_z;

        d_edge_reg <= c_edge_reg;
        d_tag_reg  <= c_tag_reg;
        d_sum_reg  <= sum3;

        e_tag_reg  <= d_tag_reg;
        e_prod_reg <= prod;
    end

    // Triangle, edge lengths, tolerance and per-vertex results
    always_ff @(posedge clk)
    begin
        if (tri_xfer)
        begin
            va_reg       <= '{x: vertex_a_x, y: vertex_a_y, z: vertex_a_z};
            vb_reg       <= '{x: vertex_b_x, y: vertex_b_y, z: vertex_b_z};
            vc_reg       <= '{x: vertex_c_x, y: vertex_c_y, z: vertex_c_z};
            res_idx_reg[0] <= '0;
            res_idx_reg[1] <= '0;
            res_idx_reg[2] <= '0;
            res_new_reg  <= '0;
            res_full_reg <= 1'b0;
        end

        if (d_v_reg && d_edge_reg)
        begin
            case (d_tag_reg[1:0])
                EDGE_AB: ab_reg <= d_sum_reg;
                EDGE_BC: bc_reg <= d_sum_reg;
                default: ca_reg <= d_sum_reg;
            endcase
        end

        if (state_reg == ST_PREP)
        begin
            tol_reg <= tol_pick;
        end

        if (scan_hit)
        begin
            res_idx_reg[vsel_reg] <= e_tag_reg;
        end
        else if (ram_we)
        begin
            res_idx_reg[vsel_reg] <= count_reg[IDX_W-1:0];
            res_new_reg[vsel_reg] <= 1'b1;
        end
        else if (scan_miss)
        begin
            res_full_reg <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            index_a_reg    <= OUT_IDX_W'(res_idx_reg[0]);
            index_b_reg    <= OUT_IDX_W'(res_idx_reg[1]);
            index_c_reg    <= OUT_IDX_W'(res_idx_reg[2]);
            new_a_reg      <= res_new_reg[0];
            new_b_reg      <= res_new_reg[1];
            new_c_reg      <= res_new_reg[2];
            table_full_reg <= res_full_reg;
        end
    end

endmodule

@@ rtl/core/mvwt_ram.sv @@
`timescale 1ns / 1ps

module mvwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/mvwt_checker.sv @@
`timescale 1ns / 1ps

module mvwt_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               tri_valid,
    input logic                               tri_stall,
    input logic                               op,
    input logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_a_x,
    input logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_a_y,
    input logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_a_z,
    input logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_b_x,
    input logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_b_y,
    input logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_b_z,
    input logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_c_x,
    input logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_c_y,
    input logic signed [mvwt_pkg::COORD_BITS-1:0] vertex_c_z,
    input logic                               weld_valid,
    input logic                               weld_stall,
    input logic [mvwt_pkg::OUT_IDX_W-1:0]     index_a,
    input logic [mvwt_pkg::OUT_IDX_W-1:0]     index_b,
    input logic [mvwt_pkg::OUT_IDX_W-1:0]     index_c,
    input logic                               new_a,
    input logic                               new_b,
    input logic                               new_c,
    input logic                               table_full
);

    import mvwt_pkg::*;

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        weld_valid && weld_stall |=> weld_valid && $stable(index_a) && $stable(index_b)
            && $stable(index_c) && $stable(table_full))
        else $error("stalled weld result changed");

    // Vertices appended in one triangle take consecutive slots
    assert property (@(posedge clk) disable iff (!rst_n)
        weld_valid && new_a && new_b |-> index_b == OUT_IDX_W'(index_a + 1'b1))
        else $error("new a and b not in consecutive slots");

    assert property (@(posedge clk) disable iff (!rst_n)
        weld_valid && new_b && new_c |-> index_c == OUT_IDX_W'(index_b + 1'b1))
        else $error("new b and c not in consecutive slots");

    // Once the table overflows, the last vertex cannot be appended
    assert property (@(posedge clk) disable iff (!rst_n)
        weld_valid && new_c |-> !table_full)
        else $error("last vertex appended after table overflow");

    // One triangle in flight: busy right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        tri_valid && !tri_stall |=> tri_stall)
        else $error("second triangle accepted while busy");

endmodule

bind mesh_vertex_weld_table mvwt_checker u_mvwt_checker (.*);
